// ----- design/opi_pkg.sv -----
// Shared widths, constants and arithmetic tables for the optical pose integrator.
package opi_pkg;

    localparam int COUNT_W    = 8;
    localparam int LIMIT_W    = 9;
    localparam int GAIN_W     = 16;
    localparam int TPC_W      = 24;
    localparam int POSE_W     = 32;
    localparam int ANGLE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int STEP_W     = 30;
    localparam int DELTA_W    = 32;
    localparam int STEP_SHIFT = 24;
    localparam int HEAD_SHIFT = 8;
    localparam int ROT_SHIFT  = 30;

    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_DEPTH = 30;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_XY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_THETA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FORWARD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TURN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_PER_CNT  = 3'd4;

    localparam logic [GAIN_W-1:0]         GAIN_XY_RST     = 16'd256;
    localparam logic [GAIN_W-1:0]         GAIN_THETA_RST  = 16'd256;
    localparam logic signed [LIMIT_W-1:0] LIMIT_RST       = 9'sd128;
    localparam logic [TPC_W-1:0]          TPC_RST         = 24'd434064;

    // 0.0635 mm per count, Q0.32
    localparam logic signed [MUL_W-1:0] MM_PER_COUNT = 32'sd272730423;
    // 0.607252935, Q1.30
    localparam logic signed [ANGLE_W-1:0] CORDIC_START = 32'sd652032874;

    localparam logic [PROD_W-1:0] HALF_STEP = PROD_W'(1) << (STEP_SHIFT - 1);
    localparam logic [PROD_W-1:0] HALF_HEAD = PROD_W'(1) << (HEAD_SHIFT - 1);
    localparam logic [PROD_W-1:0] HALF_ROT  = PROD_W'(1) << (ROT_SHIFT - 1);

    function automatic logic signed [ANGLE_W-1:0] opi_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sh20000000;
            5'd1:    v = 32'sh12E4051E;
            5'd2:    v = 32'sh09FB385B;
            5'd3:    v = 32'sh051111D4;
            5'd4:    v = 32'sh028B0D43;
            5'd5:    v = 32'sh0145D7E1;
            5'd6:    v = 32'sh00A2F61E;
            5'd7:    v = 32'sh00517C55;
            5'd8:    v = 32'sh0028BE53;
            5'd9:    v = 32'sh00145F2F;
            5'd10:   v = 32'sh000A2F98;
            5'd11:   v = 32'sh000517CC;
            5'd12:   v = 32'sh00028BE6;
            5'd13:   v = 32'sh000145F3;
            5'd14:   v = 32'sh0000A2FA;
            5'd15:   v = 32'sh0000517D;
            5'd16:   v = 32'sh000028BE;
            5'd17:   v = 32'sh0000145F;
            5'd18:   v = 32'sh00000A30;
            5'd19:   v = 32'sh00000518;
            5'd20:   v = 32'sh0000028C;
            5'd21:   v = 32'sh00000146;
            5'd22:   v = 32'sh000000A3;
            5'd23:   v = 32'sh00000051;
            5'd24:   v = 32'sh00000029;
            5'd25:   v = 32'sh00000014;
            5'd26:   v = 32'sh0000000A;
            5'd27:   v = 32'sh00000005;
            5'd28:   v = 32'sh00000003;
            5'd29:   v = 32'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/opi_if.sv -----
// Handshake channels of the pose integrator: sensor items, pose results, register writes.
interface opi_in_if;
    import opi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COUNT_W-1:0]  dx_count;
    logic signed [COUNT_W-1:0]  dy_count;
    modport source (output valid, dx_count, dy_count, input ready);
    modport sink (input valid, dx_count, dy_count, output ready);
endinterface

interface opi_out_if;
    import opi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [POSE_W-1:0]   pose_x;
    logic signed [POSE_W-1:0]   pose_y;
    logic [ANGLE_W-1:0]         heading;
    logic                       position_updated;
    logic                       heading_updated;
    modport source (output valid, pose_x, pose_y, heading, position_updated,
                    heading_updated, input ready);
    modport sink (input valid, pose_x, pose_y, heading, position_updated,
                  heading_updated, output ready);
endinterface

interface opi_cfg_if;
    import opi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_IDX_W-1:0]       index;
    logic [CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/opi_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module opi_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [opi_pkg::ANGLE_W-1:0]           i_angle,
    output logic                                  o_done,
    output logic signed [opi_pkg::ANGLE_W-1:0]    o_cos,
    output logic signed [opi_pkg::ANGLE_W-1:0]    o_sin
);
    import opi_pkg::*;

    localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    logic                       r_busy;
    logic [ITER_W-1:0]          r_iter;
    logic signed [ANGLE_W-1:0]  r_x;
    logic signed [ANGLE_W-1:0]  r_y;
    logic signed [ANGLE_W-1:0]  r_z;
    logic [1:0]                 r_quad;

    logic signed [ANGLE_W-1:0]  x_sh;
    logic signed [ANGLE_W-1:0]  y_sh;
    logic signed [ANGLE_W-1:0]  atan_v;

    assign x_sh   = r_x >>> r_iter;
    assign y_sh   = r_y >>> r_iter;
    assign atan_v = opi_atan(ATAN_IDX_W'(r_iter));
    assign o_done = r_busy && (r_iter == ITER_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + ITER_W'(1);
            if (r_iter == ITER_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_START;
            r_y    <= '0;
            r_z    <= $signed({2'b00, i_angle[ANGLE_W-3:0]});
            r_quad <= i_angle[ANGLE_W-1:ANGLE_W-2];
        end else if (r_busy) begin
            if (!r_z[ANGLE_W-1]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_v;
            end
        end
    end

    // map the residual rotation back to the full circle
    always_comb begin
        case (r_quad)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

endmodule

// ----- design/optical_odometry_pose_integrator.sv -----
// Optical odometry pose integrator: dead reckoning of X, Y and heading from sensor counts.
// A sensor item is accepted in the idle state. When it is through, the result is loaded into
// the output register and the block is ready again, so no new item is taken while one is in
// flight. The item passes through the iterative CORDIC, one micro-rotation per cycle, and the
// single 32x32 multiplier, which forms the forward step, the heading step and the two rotated
// position deltas in turn. A result still waiting in the output register holds the block in
// its last state until it is taken.
// Position is saturating Q16.16 mm held in POSITION_BITS, heading a wrapping binary angle.
// Write registers only while no item is in flight; a write applies to the next item.
module optical_odometry_pose_integrator #(
    parameter int CORDIC_STEPS  = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    opi_in_if.sink     i_item,
    opi_out_if.source  o_result,
    opi_cfg_if.sink    i_cfg
);
    import opi_pkg::*;

    localparam int SUM_W = ((POSITION_BITS > DELTA_W) ? POSITION_BITS : DELTA_W) + 1;
    localparam int EXT_W = (POSITION_BITS > POSE_W) ? POSITION_BITS : POSE_W;
    localparam logic signed [SUM_W-1:0] POS_MAX =
        (SUM_W'(1) <<< (POSITION_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);
    localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'(64'sd2147483647);
    localparam logic signed [EXT_W-1:0] OUT_MIN = EXT_W'(-64'sd2147483648);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_SCALE_A = 10'b0000000010,
        ST_SCALE_B = 10'b0000000100,
        ST_TURN_A  = 10'b0000001000,
        ST_TURN_B  = 10'b0000010000,
        ST_CORDIC  = 10'b0000100000,
        ST_ROT_X   = 10'b0001000000,
        ST_ROT_Y   = 10'b0010000000,
        ST_UPDATE  = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;

    logic [GAIN_W-1:0]               r_gain_xy;
    logic [GAIN_W-1:0]               r_gain_theta;
    logic signed [LIMIT_W-1:0]       r_limit_fwd;
    logic signed [LIMIT_W-1:0]       r_limit_turn;
    logic [TPC_W-1:0]                r_tpc;

    logic signed [POSITION_BITS-1:0] r_px;
    logic signed [POSITION_BITS-1:0] r_py;
    logic [ANGLE_W-1:0]              r_heading;

    logic signed [COUNT_W-1:0]       r_dy;
    logic signed [LIMIT_W-1:0]       r_turn;
    logic                            r_pos_ok;
    logic                            r_head_ok;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [STEP_W-1:0]        r_step;
    logic [ANGLE_W-1:0]              r_hstep;

    logic                            r_out_valid;
    logic signed [POSE_W-1:0]        r_out_x;
    logic signed [POSE_W-1:0]        r_out_y;
    logic [ANGLE_W-1:0]              r_out_heading;
    logic                            r_out_pos_upd;
    logic                            r_out_head_upd;

    logic                            in_take;
    logic                            out_free;
    logic signed [LIMIT_W-1:0]       in_turn;
    logic signed [MUL_W-1:0]         mul_a;
    logic signed [MUL_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]        mul_p;
    logic [PROD_W-1:0]               rnd_half;
    logic [PROD_W-1:0]               rnd;
    logic signed [DELTA_W-1:0]       delta;
    logic                            cordic_done;
    logic signed [ANGLE_W-1:0]       cordic_cos;
    logic signed [ANGLE_W-1:0]       cordic_sin;

    function automatic logic signed [POSITION_BITS-1:0] sat_add(
        input logic signed [POSITION_BITS-1:0] pos,
        input logic signed [DELTA_W-1:0]       d
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(pos) + SUM_W'(d);
        if (s > POS_MAX) begin
            s = POS_MAX;
        end else if (s < POS_MIN) begin
            s = POS_MIN;
        end
        return POSITION_BITS'(s);
    endfunction

    function automatic logic signed [POSE_W-1:0] clamp_out(
        input logic signed [POSITION_BITS-1:0] pos
    );
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(pos);
        if (e > OUT_MAX) begin
            e = OUT_MAX;
        end else if (e < OUT_MIN) begin
            e = OUT_MIN;
        end
        return POSE_W'(e);
    endfunction

    opi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_TURN_B),
        .i_angle (r_heading),
        .o_done  (cordic_done),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin)
    );

    assign i_item.ready = (r_state == ST_IDLE);
    assign in_take      = i_item.valid && (r_state == ST_IDLE);
    assign in_turn      = -LIMIT_W'(i_item.dx_count);
    assign out_free     = !r_out_valid || o_result.ready;

    assign i_cfg.ready  = 1'b1;

    assign o_result.valid            = r_out_valid;
    assign o_result.pose_x           = r_out_x;
    assign o_result.pose_y           = r_out_y;
    assign o_result.heading          = r_out_heading;
    assign o_result.position_updated = r_out_pos_upd;
    assign o_result.heading_updated  = r_out_head_upd;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_SCALE_A: begin
                mul_a = MUL_W'(r_dy);
                mul_b = $signed({{(MUL_W - GAIN_W){1'b0}}, r_gain_xy});
            end
            ST_SCALE_B: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = MM_PER_COUNT;
            end
            ST_TURN_A: begin
                mul_a = MUL_W'(r_turn);
                mul_b = $signed({{(MUL_W - GAIN_W){1'b0}}, r_gain_theta});
            end
            ST_TURN_B: begin
                mul_a = r_prod[MUL_W-1:0];
                mul_b = $signed({{(MUL_W - TPC_W){1'b0}}, r_tpc});
            end
            ST_ROT_X: begin
                mul_a = MUL_W'(r_step);
                mul_b = cordic_cos;
            end
            ST_ROT_Y: begin
                mul_a = MUL_W'(r_step);
                mul_b = cordic_sin;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // shared round-half-away-from-zero adder
    always_comb begin
        case (r_state)
            ST_TURN_A: rnd_half = HALF_STEP;
            ST_ROT_X:  rnd_half = HALF_HEAD;
            ST_ROT_Y:  rnd_half = HALF_ROT;
            ST_UPDATE: rnd_half = HALF_ROT;
            default:   rnd_half = '0;
        endcase
    end

    assign rnd   = r_prod + rnd_half - PROD_W'(r_prod[PROD_W-1]);
    assign delta = $signed(rnd[ROT_SHIFT+DELTA_W-1:ROT_SHIFT]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_item.valid) n_state = ST_SCALE_A;
            ST_SCALE_A: n_state = ST_SCALE_B;
            ST_SCALE_B: n_state = ST_TURN_A;
            ST_TURN_A:  n_state = ST_TURN_B;
            ST_TURN_B:  n_state = ST_CORDIC;
            ST_CORDIC:  if (cordic_done) n_state = ST_ROT_X;
            ST_ROT_X:   n_state = ST_ROT_Y;
            ST_ROT_Y:   n_state = ST_UPDATE;
            ST_UPDATE:  n_state = ST_DONE;
            ST_DONE:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_gain_xy    <= GAIN_XY_RST;
            r_gain_theta <= GAIN_THETA_RST;
            r_limit_fwd  <= LIMIT_RST;
            r_limit_turn <= LIMIT_RST;
            r_tpc        <= TPC_RST;
            r_px         <= '0;
            r_py         <= '0;
            r_heading    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_GAIN_XY:       r_gain_xy    <= i_cfg.data[GAIN_W-1:0];
                    REG_GAIN_THETA:    r_gain_theta <= i_cfg.data[GAIN_W-1:0];
                    REG_LIMIT_FORWARD: r_limit_fwd  <= $signed(i_cfg.data[LIMIT_W-1:0]);
                    REG_LIMIT_TURN:    r_limit_turn <= $signed(i_cfg.data[LIMIT_W-1:0]);
                    REG_TURN_PER_CNT:  r_tpc        <= i_cfg.data[TPC_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_ROT_Y && r_pos_ok) begin
                r_px <= sat_add(r_px, delta);
            end
            if (r_state == ST_UPDATE) begin
                if (r_pos_ok) begin
                    r_py <= sat_add(r_py, delta);
                end
                if (r_head_ok) begin
                    r_heading <= r_heading + r_hstep;
                end
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_dy      <= i_item.dy_count;
            r_turn    <= in_turn;
            r_pos_ok  <= LIMIT_W'(i_item.dy_count) < r_limit_fwd;
            r_head_ok <= in_turn < r_limit_turn;
        end
        case (r_state)
            ST_SCALE_A, ST_SCALE_B, ST_TURN_B, ST_ROT_X, ST_ROT_Y: r_prod <= mul_p;
            ST_TURN_A: begin
                r_prod <= mul_p;
                r_step <= $signed(rnd[STEP_SHIFT+STEP_W-1:STEP_SHIFT]);
            end
            default: ;
        endcase
        if (r_state == ST_ROT_X) begin
            r_hstep <= rnd[HEAD_SHIFT+ANGLE_W-1:HEAD_SHIFT];
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_x        <= clamp_out(r_px);
            r_out_y        <= clamp_out(r_py);
            r_out_heading  <= r_heading;
            r_out_pos_upd  <= r_pos_ok;
            r_out_head_upd <= r_head_ok;
        end
    end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the optical pose integrator: predicts every pose item and checks it.
import opi_pkg::*;

localparam int     CORDIC_ITERS     = 16;
localparam int     POS_BITS         = 32;
localparam longint MM_PER_COUNT_Q32 = 64'sd272730423;
localparam longint CORDIC_GAIN_Q30  = 64'sd652032874;
localparam int     ATAN_COUNT       = 30;
localparam longint ATAN_BAM [0:ATAN_COUNT-1] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
};

typedef struct packed {
    logic signed [POSE_W-1:0] x;
    logic signed [POSE_W-1:0] y;
    logic [ANGLE_W-1:0]       heading;
    logic                     pos_upd;
    logic                     head_upd;
} t_pose;

class pose_tracker;
    logic [GAIN_W-1:0]         gain_xy;
    logic [GAIN_W-1:0]         gain_theta;
    logic signed [LIMIT_W-1:0] lim_fwd;
    logic signed [LIMIT_W-1:0] lim_turn;
    logic [TPC_W-1:0]          turn_per_count;
    longint                    pos_x;
    longint                    pos_y;
    logic [ANGLE_W-1:0]        head;
    t_pose                     pose_due[$];
    int                        errors;

    function new();
        gain_xy        = 16'd256;
        gain_theta     = 16'd256;
        lim_fwd        = 9'sd128;
        lim_turn       = 9'sd128;
        turn_per_count = 24'd434064;
        pos_x          = 0;
        pos_y          = 0;
        head           = '0;
        errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_XY:       gain_xy        = data[GAIN_W-1:0];
            REG_GAIN_THETA:    gain_theta     = data[GAIN_W-1:0];
            REG_LIMIT_FORWARD: lim_fwd        = data[LIMIT_W-1:0];
            REG_LIMIT_TURN:    lim_turn       = data[LIMIT_W-1:0];
            REG_TURN_PER_CNT:  turn_per_count = data[TPC_W-1:0];
            default: ;
        endcase
    endfunction

    function longint round_away(longint v, int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (v >= 0)
            return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function void cos_sin(logic [ANGLE_W-1:0] ang, output longint c, output longint s);
        longint vx;
        longint vy;
        longint z;
        longint xs;
        longint ys;
        vx = CORDIC_GAIN_Q30;
        vy = 0;
        z  = longint'(ang[29:0]);
        for (int i = 0; i < CORDIC_ITERS && i < ATAN_COUNT; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (z >= 0) begin
                vx = vx - ys;
                vy = vy + xs;
                z  = z - ATAN_BAM[i];
            end else begin
                vx = vx + ys;
                vy = vy - xs;
                z  = z + ATAN_BAM[i];
            end
        end
        case (ang[31:30])
            2'd0: begin c = vx;  s = vy;  end
            2'd1: begin c = -vy; s = vx;  end
            2'd2: begin c = -vx; s = -vy; end
            default: begin c = vy; s = -vx; end
        endcase
    endfunction

    function void track_counts(logic signed [COUNT_W-1:0] dx, logic signed [COUNT_W-1:0] dy);
        longint fwd;
        longint turn;
        longint step;
        longint c;
        longint s;
        longint d;
        t_pose  p;
        fwd  = longint'(dy);
        turn = -longint'(dx);
        p.pos_upd  = fwd < longint'(lim_fwd);
        p.head_upd = turn < longint'(lim_turn);
        if (p.pos_upd) begin
            step = round_away(fwd * MM_PER_COUNT_Q32 * longint'(gain_xy), 24);
            cos_sin(head, c, s);
            pos_x = clamp(pos_x + round_away(step * c, 30), POS_BITS);
            pos_y = clamp(pos_y + round_away(step * s, 30), POS_BITS);
        end
        if (p.head_upd) begin
            d = round_away(turn * longint'(turn_per_count) * longint'(gain_theta), 8);
            head = head + d[ANGLE_W-1:0];
        end
        p.x       = POSE_W'(clamp(pos_x, 32));
        p.y       = POSE_W'(clamp(pos_y, 32));
        p.heading = head;
        pose_due.push_back(p);
    endfunction

    function void compare_pose(t_pose got);
        t_pose want;
        if (pose_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("pose item with none pending: x %0d y %0d heading %h",
                         got.x, got.y, got.heading);
            return;
        end
        want = pose_due.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading ||
            got.pos_upd !== want.pos_upd || got.head_upd !== want.head_upd) begin
            errors++;
            if (errors <= 10)
                $display("pose mismatch: x %0d/%0d y %0d/%0d heading %h/%h flags %b%b/%b%b",
                         want.x, got.x, want.y, got.y, want.heading, got.heading,
                         want.pos_upd, want.head_upd, got.pos_upd, got.head_upd);
        end
    endfunction

    function int pending();
        return pose_due.size();
    endfunction
endclass

module tb;
    localparam int                   LATENCY        = CORDIC_ITERS + 9;
    localparam int                   WATCHDOG_LIMIT = 40 * LATENCY;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = 3'd7;

    logic        clk;
    logic        rst_n;
    bit          idle_on;
    int          stall_left;
    int          quiet;
    t_pose       seen;
    pose_tracker sb;

    opi_in_if  in_ch();
    opi_out_if res_ch();
    opi_cfg_if cfg_ch();

    optical_odometry_pose_integrator #(
        .CORDIC_STEPS (CORDIC_ITERS),
        .POSITION_BITS(POS_BITS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (in_ch),
        .o_result(res_ch),
        .i_cfg   (cfg_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            seen.x        = res_ch.pose_x;
            seen.y        = res_ch.pose_y;
            seen.heading  = res_ch.heading;
            seen.pos_upd  = res_ch.position_updated;
            seen.head_upd = res_ch.heading_updated;
            sb.compare_pose(seen);
        end
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic signed [COUNT_W-1:0] dx,
                             input logic signed [COUNT_W-1:0] dy);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.dx_count <= dx;
        in_ch.dy_count <= dy;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.track_counts(dx, dy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // hold the sender until every pose item is back, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic configure(input logic [GAIN_W-1:0] gxy, input logic [GAIN_W-1:0] gth,
                             input logic signed [LIMIT_W-1:0] lf,
                             input logic signed [LIMIT_W-1:0] lt,
                             input logic [TPC_W-1:0] tpc);
        drain();
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_GAIN_XY, {8'($urandom), gxy});
        write_reg(REG_GAIN_THETA, {8'($urandom), gth});
        write_reg(REG_LIMIT_FORWARD, {15'($urandom), lf});
        write_reg(REG_LIMIT_TURN, {15'($urandom), lt});
        write_reg(REG_TURN_PER_CNT, tpc);
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 16'd256;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [LIMIT_W-1:0] pick_limit();
        int v;
        case ($urandom_range(0, 5))
            0: v = -128;
            1: v = 128;
            2: v = 0;
            default: v = int'($urandom_range(0, 256)) - 128;
        endcase
        return LIMIT_W'(v);
    endfunction

    function automatic logic [TPC_W-1:0] pick_tpc();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 24'd434064;
            default: return TPC_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COUNT_W-1:0] pick_count();
        logic signed [COUNT_W-1:0] edges [5] = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1, 8'sd1};
        case ($urandom_range(0, 5))
            0: return edges[$urandom_range(0, 4)];
            1: return COUNT_W'(int'($urandom_range(0, 16)) - 8);
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    task automatic run_items(input int n);
        int  sent;
        int  len;
        bit  back;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 3) begin
                // straight run: little turn, forward counts of one sign
                len  = $urandom_range(5, 30);
                back = 1'($urandom_range(0, 1));
                for (int j = 0; j < len; j++)
                    send_item(COUNT_W'(int'($urandom_range(0, 2)) - 1),
                              back ? COUNT_W'(-int'($urandom_range(64, 128)))
                                   : COUNT_W'($urandom_range(64, 127)));
                sent += len;
            end else begin
                send_item(pick_count(), pick_count());
                sent++;
            end
        end
    endtask

    initial begin
        sb           = new();
        idle_on      = 1'b1;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.dx_count <= '0;
        in_ch.dy_count <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(8'sd0, 8'sd0);
        send_item(8'sd127, 8'sd127);
        send_item(-8'sd128, -8'sd128);
        send_item(-8'sd128, 8'sd0);
        send_item(8'sd0, -8'sd128);
        send_item(8'sd85, -8'sd86);
        send_item(-8'sd86, 8'sd85);
        send_item(8'sd1, -8'sd1);

        configure('1, '1, 9'sd128, 9'sd128, '1);
        send_item(-8'sd1, 8'sd127);
        send_item(8'sd127, -8'sd128);
        send_item(-8'sd128, 8'sd127);
        send_item(8'sd3, 8'sd100);

        configure('0, '0, 9'sd128, 9'sd128, 24'd434064);
        send_item(-8'sd5, 8'sd60);
        send_item(8'sd100, -8'sd100);
        send_item(8'sd0, 8'sd0);

        configure(16'd256, 16'd256, -9'sd128, -9'sd128, 24'd434064);
        send_item(-8'sd128, -8'sd128);
        send_item(8'sd127, 8'sd127);
        send_item(8'sd0, 8'sd0);

        configure(16'd256, 16'd256, 9'sd0, 9'sd0, '0);
        send_item(8'sd1, -8'sd1);
        send_item(8'sd0, 8'sd0);
        send_item(-8'sd1, 8'sd1);

        configure(16'd512, 16'd256, 9'sd127, -9'sd127, 24'd434064);
        send_item(8'sd127, 8'sd126);
        send_item(8'sd127, 8'sd127);

        for (int ph = 0; ph < 10; ph++) begin
            configure(pick_gain(), pick_gain(), pick_limit(), pick_limit(), pick_tpc());
            idle_on = (ph < 9) ? ($urandom_range(0, 3) != 0) : 1'b0;
            run_items(188);
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
